/* hw/rtl/pldp_pkg.sv */
package pldp_pkg;

    localparam int COORD_W        = 24;
    localparam int TOL_W          = 23;
    localparam int INDEX_W        = 6;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 3;
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 24;

    // register word offsets
    localparam logic [0:0] REG_TOLERANCE = 1'b0;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic                      keep_in;
        logic                      last_in;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic [INDEX_W-1:0]        out_index;
        logic                      out_last;
    } out_word_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

/* hw/rtl/pldp_muldiv.sv */
// floor(a*b/c) for b < c: shift-and-add over the bits of a, reduced modulo c
module pldp_muldiv #(
    parameter int AW = 25,
    parameter int BW = 50
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [AW-1:0]        a,
    input  logic [BW-1:0]        b,
    input  logic [BW-1:0]        c,
    output pldp_pkg::div_ctl_t   status,
    output logic [AW-1:0]        q
);

    localparam int CNT_W = $clog2(AW + 1);

    logic [AW-1:0]    a_reg;
    logic [BW-1:0]    b_reg;
    logic [BW-1:0]    c_reg;
    logic [BW-1:0]    r_reg;
    logic [AW-1:0]    q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             phase_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [BW:0]      r_dbl;
    logic [BW:0]      r_add;

    assign r_dbl = {r_reg, 1'b0};
    assign r_add = {1'b0, r_reg} + (a_reg[AW-1] ? {1'b0, b_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg     <= a;
                b_reg     <= b;
                c_reg     <= c;
                r_reg     <= '0;
                q_reg     <= '0;
                cnt_reg   <= CNT_W'(AW);
                phase_reg <= 1'b0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!phase_reg)
                begin
                    if (r_dbl >= {1'b0, c_reg})
                    begin
                        r_reg <= BW'(r_dbl - {1'b0, c_reg});
                        q_reg <= {q_reg[AW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= BW'(r_dbl);
                        q_reg <= {q_reg[AW-2:0], 1'b0};
                    end
                    phase_reg <= 1'b1;
                end
                else
                begin
                    if (r_add >= {1'b0, c_reg})
                    begin
                        r_reg <= BW'(r_add - {1'b0, c_reg});
                        q_reg <= q_reg + AW'(1);
                    end
                    else
                    begin
                        r_reg <= BW'(r_add);
                    end
                    a_reg     <= {a_reg[AW-2:0], 1'b0};
                    phase_reg <= 1'b0;
                    cnt_reg   <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign status.start = busy_reg;
    assign status.done  = done_reg;
    assign q            = q_reg;

endmodule

/* hw/rtl/polyline_douglas_peucker_core.sv */
// Loading: one vertex per cycle; the word carrying last_in starts the simplifier.
// Simplify: each inner vertex of a segment is measured in turn, with two passes
//   of the mul-div unit where the foot of the perpendicular is needed.
// Output: each vertex is scanned in states S_E0 and S_E1, one word per kept vertex.
// Throughput: one polyline at a time; no new word is taken until the last is loaded for output.
// Reset: asynchronous active low; clears control, count and tolerance, not the stores.
module polyline_douglas_peucker_core #(
    parameter int MAX_POINTS = pldp_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = pldp_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pldp_pkg::in_word_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pldp_pkg::out_word_t         out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pldp_pkg::ADDR_W-1:0] paddr,
    input  logic [pldp_pkg::DATA_W-1:0] pwdata,
    output logic [pldp_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int CW    = COORD_BITS;
    localparam int IW    = $clog2(MAX_POINTS);
    localparam int NW    = IW + 1;
    localparam int OW    = (CW + 2 > pldp_pkg::TOL_W + 1) ? CW + 2 : pldp_pkg::TOL_W + 1;
    localparam int DW    = 2 * OW;
    localparam int AW    = CW + 1;
    localparam int BW    = 2 * CW + 2;

    typedef enum logic [5:0] {
        S_LOAD, S_MARK0, S_MARKN, S_POP, S_POPW, S_RDJ, S_RDK, S_SEGU,
        S_U0, S_U1, S_U2, S_RI, S_W0, S_W1, S_W2, S_W3, S_BR, S_QX, S_QY,
        S_PD, S_D0, S_D1, S_D2, S_CMP, S_PB, S_PBW, S_PF, S_PFW, S_DEC,
        S_PUSH1, S_PUSH2, S_E0, S_E1
    } state_t;

    state_t state_reg;

    logic [pldp_pkg::TOL_W-1:0] tol_reg;
    logic [NW-1:0] vcount_reg, n_reg, i_reg, j_reg, k_reg, t_reg, e_reg, maxi_reg, sp_reg;

    logic signed [CW-1:0] xmem [MAX_POINTS];
    logic signed [CW-1:0] ymem [MAX_POINTS];
    logic                 mmem [MAX_POINTS];
    logic [2*IW-1:0]      smem [MAX_POINTS];

    logic signed [CW-1:0] rdx_reg, rdy_reg;
    logic                 rdm_reg;
    logic [2*IW-1:0]      rds_reg;
    logic [IW-1:0]        ra;

    logic signed [CW-1:0] xj_reg, yj_reg, xk_reg, yk_reg, xi_reg, yi_reg;
    logic signed [OW-1:0] wx_reg, wy_reg, dx_reg, dy_reg;
    logic signed [CW+1:0] px_reg;
    logic signed [DW-1:0] prod_reg, acc_reg, cu_reg, cw_reg, dv_reg, maxd_reg, tol2_reg;
    logic signed [OW-1:0] opa, opb;
    logic signed [CW:0]   ux, uy;

    logic                 xy_we, mk_we, mk_wd, st_we;
    logic [IW-1:0]        xy_wa, mk_wa, st_wa;
    logic [2*IW-1:0]      st_wd;
    logic                 in_acc, full, drop;

    logic                 div_start;
    logic [AW-1:0]        div_a, div_q;
    pldp_pkg::div_ctl_t   div_st;
    logic signed [CW+1:0] q_s;
    logic                 can_load;
    logic                 out_load;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pldp_pkg::REG_TOLERANCE) ? pldp_pkg::DATA_W'(tol_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (psel && penable && pwrite && pready && paddr[2] == pldp_pkg::REG_TOLERANCE)
            tol_reg <= pwdata[pldp_pkg::TOL_W-1:0];
    end

    assign in_ready = (state_reg == S_LOAD);
    assign in_acc   = in_valid && in_ready;
    assign full     = (vcount_reg >= NW'(MAX_POINTS));
    assign drop     = full && !in_data.last_in;

    assign ux = (CW+1)'(xk_reg) - (CW+1)'(xj_reg);
    assign uy = (CW+1)'(yk_reg) - (CW+1)'(yj_reg);

    // read address for the vertex stores
    always_comb
    begin
        unique case (state_reg)
            S_RDJ:        ra = j_reg[IW-1:0];
            S_RDK:        ra = k_reg[IW-1:0];
            S_PB, S_PBW:  ra = IW'(t_reg - NW'(1));
            S_PF, S_PFW:  ra = t_reg[IW-1:0];
            S_E0, S_E1:   ra = e_reg[IW-1:0];
            default:      ra = i_reg[IW-1:0];
        endcase
    end

    // write ports
    always_comb
    begin
        xy_we = in_acc && !drop;
        xy_wa = full ? IW'(MAX_POINTS - 1) : vcount_reg[IW-1:0];
        mk_we = 1'b0;
        mk_wa = xy_wa;
        mk_wd = 1'b1;
        st_we = 1'b0;
        st_wa = sp_reg[IW-1:0];
        st_wd = {maxi_reg[IW-1:0], k_reg[IW-1:0]};
        unique case (state_reg)
            S_LOAD:
            begin
                mk_we = xy_we;
                mk_wd = in_data.keep_in;
            end
            S_MARK0:
            begin
                mk_we = 1'b1;
                mk_wa = '0;
            end
            S_MARKN:
            begin
                mk_we = 1'b1;
                mk_wa = IW'(n_reg - NW'(1));
                st_we = (n_reg >= NW'(3));
                st_wa = '0;
                st_wd = {IW'(0), IW'(n_reg - NW'(1))};
            end
            S_DEC:
            begin
                mk_we = (maxd_reg > tol2_reg);
                mk_wa = maxi_reg[IW-1:0];
            end
            S_PUSH1:
                st_we = (sp_reg < NW'(MAX_POINTS));
            S_PUSH2:
            begin
                st_we = (sp_reg < NW'(MAX_POINTS));
                st_wd = {j_reg[IW-1:0], maxi_reg[IW-1:0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (xy_we)
        begin
            xmem[xy_wa] <= in_data.x_coord[CW-1:0];
            ymem[xy_wa] <= in_data.y_coord[CW-1:0];
        end
        rdx_reg <= xmem[ra];
        rdy_reg <= ymem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (mk_we)
            mmem[mk_wa] <= mk_wd;
        rdm_reg <= mmem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            smem[st_wa] <= st_wd;
        rds_reg <= smem[IW'(sp_reg - NW'(1))];
    end

    // shared multiplier operands
    always_comb
    begin
        unique case (state_reg)
            S_MARK0:
            begin
                opa = OW'(signed'({1'b0, tol_reg}));
                opb = opa;
            end
            S_U0:
            begin
                opa = OW'(ux);
                opb = OW'(ux);
            end
            S_U1:
            begin
                opa = OW'(uy);
                opb = OW'(uy);
            end
            S_W1:
            begin
                opa = wx_reg;
                opb = OW'(ux);
            end
            S_W2:
            begin
                opa = wy_reg;
                opb = OW'(uy);
            end
            S_D1:
            begin
                opa = dy_reg;
                opb = dy_reg;
            end
            default:
            begin
                opa = dx_reg;
                opb = dx_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
    end

    assign div_start = (state_reg == S_BR && cw_reg > 0 && cu_reg > cw_reg)
                    || (state_reg == S_QX && div_st.done);
    assign div_a     = (state_reg == S_BR) ? AW'(ux < 0 ? -ux : ux) : AW'(uy < 0 ? -uy : uy);
    assign q_s       = signed'((CW+2)'(div_q));

    pldp_muldiv #(
        .AW(AW),
        .BW(BW)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (cw_reg[BW-1:0]),
        .c     (cu_reg[BW-1:0]),
        .status(div_st),
        .q     (div_q)
    );

    assign can_load = !out_valid || out_ready;
    assign out_load = (state_reg == S_E1) && rdm_reg && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            vcount_reg <= '0;
            sp_reg     <= '0;
            out_valid  <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready && !out_load)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc && !drop)
                    begin
                        if (!full)
                            vcount_reg <= vcount_reg + NW'(1);
                        if (in_data.last_in)
                        begin
                            n_reg     <= full ? vcount_reg : vcount_reg + NW'(1);
                            state_reg <= S_MARK0;
                        end
                    end
                end
                S_MARK0:
                    state_reg <= S_MARKN;
                S_MARKN:
                begin
                    tol2_reg  <= prod_reg;
                    sp_reg    <= (n_reg >= NW'(3)) ? NW'(1) : '0;
                    state_reg <= S_POP;
                end
                S_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        e_reg     <= '0;
                        state_reg <= S_E0;
                    end
                    else
                    begin
                        sp_reg    <= sp_reg - NW'(1);
                        state_reg <= S_POPW;
                    end
                end
                S_POPW:
                begin
                    j_reg <= NW'(rds_reg[2*IW-1:IW]);
                    k_reg <= NW'(rds_reg[IW-1:0]);
                    if (NW'(rds_reg[IW-1:0]) >= n_reg
                        || NW'(rds_reg[IW-1:0]) <= NW'(rds_reg[2*IW-1:IW]) + NW'(1))
                        state_reg <= S_POP;
                    else
                        state_reg <= S_RDJ;
                end
                S_RDJ:
                    state_reg <= S_RDK;
                S_RDK:
                begin
                    xj_reg    <= rdx_reg;
                    yj_reg    <= rdy_reg;
                    state_reg <= S_SEGU;
                end
                S_SEGU:
                begin
                    xk_reg    <= rdx_reg;
                    yk_reg    <= rdy_reg;
                    state_reg <= S_U0;
                end
                S_U0:
                    state_reg <= S_U1;
                S_U1:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_U2;
                end
                S_U2:
                begin
                    cu_reg    <= acc_reg + prod_reg;
                    i_reg     <= j_reg + NW'(1);
                    maxd_reg  <= '0;
                    maxi_reg  <= j_reg;
                    state_reg <= S_RI;
                end
                S_RI:
                    state_reg <= (i_reg >= k_reg) ? S_DEC : S_W0;
                S_W0:
                begin
                    xi_reg    <= rdx_reg;
                    yi_reg    <= rdy_reg;
                    wx_reg    <= OW'(rdx_reg) - OW'(xj_reg);
                    wy_reg    <= OW'(rdy_reg) - OW'(yj_reg);
                    state_reg <= S_W1;
                end
                S_W1:
                    state_reg <= S_W2;
                S_W2:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_W3;
                end
                S_W3:
                begin
                    cw_reg    <= acc_reg + prod_reg;
                    state_reg <= S_BR;
                end
                S_BR:
                begin
                    if (cw_reg <= 0)
                    begin
                        dx_reg    <= wx_reg;
                        dy_reg    <= wy_reg;
                        state_reg <= S_D0;
                    end
                    else if (cu_reg <= cw_reg)
                    begin
                        dx_reg    <= OW'(xi_reg) - OW'(xk_reg);
                        dy_reg    <= OW'(yi_reg) - OW'(yk_reg);
                        state_reg <= S_D0;
                    end
                    else
                        state_reg <= S_QX;
                end
                S_QX:
                begin
                    if (div_st.done)
                    begin
                        px_reg    <= (CW+2)'(xj_reg) + ((ux < 0) ? -q_s : q_s);
                        state_reg <= S_QY;
                    end
                end
                S_QY:
                begin
                    if (div_st.done)
                    begin
                        dx_reg    <= OW'(xi_reg) - OW'(px_reg);
                        px_reg    <= (CW+2)'(yj_reg) + ((uy < 0) ? -q_s : q_s);
                        state_reg <= S_PD;
                    end
                end
                S_PD:
                begin
                    dy_reg    <= OW'(yi_reg) - OW'(px_reg);
                    state_reg <= S_D0;
                end
                S_D0:
                    state_reg <= S_D1;
                S_D1:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_D2;
                end
                S_D2:
                begin
                    dv_reg    <= acc_reg + prod_reg;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (dv_reg > maxd_reg)
                    begin
                        maxd_reg  <= dv_reg;
                        t_reg     <= i_reg;
                        state_reg <= S_PB;
                    end
                    else
                    begin
                        i_reg     <= i_reg + NW'(1);
                        state_reg <= S_RI;
                    end
                end
                // look back, then forward, along a run of equal coordinates
                S_PB:
                begin
                    if (t_reg == '0)
                    begin
                        t_reg     <= i_reg + NW'(1);
                        state_reg <= S_PF;
                    end
                    else
                        state_reg <= S_PBW;
                end
                S_PBW:
                begin
                    if (rdx_reg != xi_reg || rdy_reg != yi_reg)
                    begin
                        t_reg     <= i_reg + NW'(1);
                        state_reg <= S_PF;
                    end
                    else if (rdm_reg)
                    begin
                        maxi_reg  <= t_reg - NW'(1);
                        i_reg     <= i_reg + NW'(1);
                        state_reg <= S_RI;
                    end
                    else
                    begin
                        t_reg     <= t_reg - NW'(1);
                        state_reg <= S_PB;
                    end
                end
                S_PF:
                begin
                    if (t_reg >= n_reg)
                    begin
                        maxi_reg  <= i_reg;
                        i_reg     <= i_reg + NW'(1);
                        state_reg <= S_RI;
                    end
                    else
                        state_reg <= S_PFW;
                end
                S_PFW:
                begin
                    if (rdx_reg != xi_reg || rdy_reg != yi_reg)
                    begin
                        maxi_reg  <= i_reg;
                        i_reg     <= i_reg + NW'(1);
                        state_reg <= S_RI;
                    end
                    else if (rdm_reg)
                    begin
                        maxi_reg  <= t_reg;
                        i_reg     <= i_reg + NW'(1);
                        state_reg <= S_RI;
                    end
                    else
                    begin
                        t_reg     <= t_reg + NW'(1);
                        state_reg <= S_PF;
                    end
                end
                S_DEC:
                begin
                    if (maxd_reg > tol2_reg && maxi_reg > j_reg && maxi_reg < k_reg)
                        state_reg <= S_PUSH1;
                    else
                        state_reg <= S_POP;
                end
                S_PUSH1:
                begin
                    if (sp_reg < NW'(MAX_POINTS))
                        sp_reg <= sp_reg + NW'(1);
                    state_reg <= S_PUSH2;
                end
                S_PUSH2:
                begin
                    if (sp_reg < NW'(MAX_POINTS))
                        sp_reg <= sp_reg + NW'(1);
                    state_reg <= S_POP;
                end
                S_E0:
                    state_reg <= S_E1;
                S_E1:
                begin
                    if (!rdm_reg || can_load)
                    begin
                        if (rdm_reg)
                        begin
                            out_valid          <= 1'b1;
                            out_data.out_x     <= pldp_pkg::COORD_W'(rdx_reg);
                            out_data.out_y     <= pldp_pkg::COORD_W'(rdy_reg);
                            out_data.out_index <= pldp_pkg::INDEX_W'(e_reg);
                            out_data.out_last  <= (e_reg == n_reg - NW'(1));
                        end
                        if (e_reg == n_reg - NW'(1))
                        begin
                            vcount_reg <= '0;
                            state_reg  <= S_LOAD;
                        end
                        else
                        begin
                            e_reg     <= e_reg + NW'(1);
                            state_reg <= S_E0;
                        end
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= NW'(MAX_POINTS))
        else $error("vertex count beyond store depth");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= NW'(MAX_POINTS))
        else $error("segment stack pointer beyond depth");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last_in |=> !in_ready)
        else $error("word taken while simplifying");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == S_BR || state_reg == S_QX))
        else $error("mul-div started outside projection");

endmodule

/* dv/polyline_douglas_peucker_core_tb.sv */
`timescale 1ns / 100ps

module polyline_douglas_peucker_core_tb;

    localparam int NPTS       = pldp_pkg::MAX_POINTS_DEF;
    localparam int WDOG_LIMIT = 1500000;
    localparam int SETTLE     = 400;
    localparam int TOL_MAX    = (1 << pldp_pkg::TOL_W) - 1;
    localparam int CMAX       = (1 << (pldp_pkg::COORD_W - 1)) - 1;
    localparam int CMIN       = -(1 << (pldp_pkg::COORD_W - 1));

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    pldp_pkg::in_word_t            in_data;
    logic                          out_valid;
    logic                          out_ready;
    pldp_pkg::out_word_t           out_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [pldp_pkg::ADDR_W-1:0]   paddr;
    logic [pldp_pkg::DATA_W-1:0]   pwdata;
    logic [pldp_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // shadow of the block's state
    longint              pt_x [NPTS];
    longint              pt_y [NPTS];
    bit                  pt_keep [NPTS];
    int                  pt_count;
    longint              tol_shadow;

    pldp_pkg::out_word_t kept_q [$];
    int                  mismatches;
    int                  wdog;
    int                  out_hold;
    int                  out_stall_pct;
    bit                  in_gaps_on;
    int                  words_sent;

    polyline_douglas_peucker_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint sqd(longint ax, longint ay, longint bx, longint by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        return dx * dx + dy * dy;
    endfunction

    function automatic longint scaled_foot(longint u, longint cw, longint cu);
        logic [127:0] prod;
        logic [127:0] q;
        longint       mag;
        mag  = (u < 0) ? -u : u;
        prod = 128'(mag) * 128'(cw);
        q    = prod / 128'(cu);
        return (u < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // an already kept vertex at the same spot wins over the new one
    function automatic int pick_marked_twin(int i, int n);
        int t;
        for (t = i; t > 0; t--)
        begin
            if (pt_x[t-1] != pt_x[i] || pt_y[t-1] != pt_y[i])
                break;
            if (pt_keep[t-1])
                return t - 1;
        end
        for (t = i + 1; t < n; t++)
        begin
            if (pt_x[t] != pt_x[i] || pt_y[t] != pt_y[i])
                break;
            if (pt_keep[t])
                return t;
        end
        return i;
    endfunction

    function automatic void simplify_shadow(int n);
        int     seg_lo [NPTS];
        int     seg_hi [NPTS];
        int     sp;
        int     j;
        int     k;
        int     best;
        longint tol2;
        longint ux;
        longint uy;
        longint cu;
        longint cw;
        longint wx;
        longint wy;
        longint dv;
        longint maxd;
        sp   = 0;
        tol2 = tol_shadow * tol_shadow;
        if (n >= 3)
        begin
            seg_lo[0] = 0;
            seg_hi[0] = n - 1;
            sp = 1;
        end
        while (sp > 0)
        begin
            sp--;
            j = seg_lo[sp];
            k = seg_hi[sp];
            if (k >= n || k <= j + 1)
                continue;
            ux   = pt_x[k] - pt_x[j];
            uy   = pt_y[k] - pt_y[j];
            cu   = ux * ux + uy * uy;
            best = j;
            maxd = 0;
            for (int i = j + 1; i < k; i++)
            begin
                wx = pt_x[i] - pt_x[j];
                wy = pt_y[i] - pt_y[j];
                cw = wx * ux + wy * uy;
                if (cw <= 0)
                    dv = sqd(pt_x[i], pt_y[i], pt_x[j], pt_y[j]);
                else if (cu <= cw)
                    dv = sqd(pt_x[i], pt_y[i], pt_x[k], pt_y[k]);
                else
                    dv = sqd(pt_x[i], pt_y[i], pt_x[j] + scaled_foot(ux, cw, cu),
                             pt_y[j] + scaled_foot(uy, cw, cu));
                if (dv <= maxd)
                    continue;
                best = pick_marked_twin(i, n);
                maxd = dv;
            end
            if (maxd > tol2)
            begin
                pt_keep[best] = 1'b1;
                if (best > j && best < k)
                begin
                    if (sp < NPTS)
                    begin
                        seg_lo[sp] = best;
                        seg_hi[sp] = k;
                        sp++;
                    end
                    if (sp < NPTS)
                    begin
                        seg_lo[sp] = j;
                        seg_hi[sp] = best;
                        sp++;
                    end
                end
            end
        end
    endfunction

    function automatic void predict_kept(pldp_pkg::in_word_t w);
        int                  slot;
        int                  n;
        pldp_pkg::out_word_t o;
        if (pt_count >= NPTS)
        begin
            if (!w.last_in)
                return;
            slot = NPTS - 1;
        end
        else
        begin
            slot = pt_count;
            pt_count++;
        end
        pt_x[slot]    = longint'(w.x_coord);
        pt_y[slot]    = longint'(w.y_coord);
        pt_keep[slot] = w.keep_in;
        if (!w.last_in)
            return;
        n = pt_count;
        pt_keep[0]   = 1'b1;
        pt_keep[n-1] = 1'b1;
        simplify_shadow(n);
        for (int i = 0; i < n; i++)
        begin
            if (pt_keep[i])
            begin
                o.out_x     = pt_x[i][pldp_pkg::COORD_W-1:0];
                o.out_y     = pt_y[i][pldp_pkg::COORD_W-1:0];
                o.out_index = pldp_pkg::INDEX_W'(i);
                o.out_last  = (i == n - 1);
                kept_q.insert(kept_q.size(), o);
            end
        end
        pt_count = 0;
    endfunction

    task automatic send_vertex(int x, int y, bit keep, bit last);
        int r;
        int gap;
        gap = 0;
        if (in_gaps_on)
        begin
            r = $urandom_range(0, 99);
            if (r >= 97)
                gap = $urandom_range(20, 60);
            else if (r >= 88)
                gap = $urandom_range(4, 10);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid        <= 1'b1;
        in_data.x_coord <= pldp_pkg::COORD_W'(x);
        in_data.y_coord <= pldp_pkg::COORD_W'(y);
        in_data.keep_in <= keep;
        in_data.last_in <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_kept(in_data);
        words_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (kept_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_tolerance(int unsigned t);
        wait_drained();
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {pldp_pkg::REG_TOLERANCE, 2'b00};
        pwdata  <= pldp_pkg::DATA_W'(t);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tol_shadow = longint'(t & TOL_MAX);
    endtask

    // random walk; step size picks how far the shape strays from a line
    task automatic send_polyline(int len, int step_bits);
        int x;
        int y;
        int r;
        x = $urandom_range(0, 2000) - 1000;
        y = $urandom_range(0, 2000) - 1000;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                x = $urandom();
                x = x >>> 8;
                y = $urandom();
                y = y >>> 8;
            end
            else if (r >= 15)
            begin
                x += int'($urandom_range(0, 1 << step_bits)) - (1 << (step_bits - 1));
                y += int'($urandom_range(0, 1 << step_bits)) - (1 << (step_bits - 1));
                if (x > CMAX) x = CMAX;
                if (x < CMIN) x = CMIN;
                if (y > CMAX) y = CMAX;
                if (y < CMIN) y = CMIN;
            end
            // otherwise repeat the previous vertex
            send_vertex(x, y, ($urandom_range(0, 9) == 0), i == len - 1);
        end
    endtask

    task automatic test_short_lines();
        set_tolerance(0);
        send_vertex(5, -7, 1'b0, 1'b1);
        send_vertex(CMIN, CMAX, 1'b0, 1'b0);
        send_vertex(CMAX, CMIN, 1'b1, 1'b1);
        send_vertex(0, 0, 1'b0, 1'b0);
        send_vertex(3, 1, 1'b0, 1'b0);
        send_vertex(10, 0, 1'b0, 1'b1);
    endtask

    task automatic test_extremes();
        set_tolerance(0);
        send_vertex(CMIN, CMIN, 1'b0, 1'b0);
        send_vertex(CMAX, CMAX, 1'b0, 1'b0);
        send_vertex(CMAX, CMIN, 1'b0, 1'b0);
        send_vertex(CMIN, CMAX, 1'b0, 1'b0);
        send_vertex(-1, -1, 1'b0, 1'b1);
        set_tolerance(TOL_MAX);
        send_vertex(CMIN, 0, 1'b0, 1'b0);
        send_vertex(0, CMAX, 1'b0, 1'b0);
        send_vertex(17, 17, 1'b1, 1'b0);
        send_vertex(CMAX, 0, 1'b0, 1'b1);
    endtask

    task automatic test_twin_vertices();
        set_tolerance(2);
        send_vertex(0, 0, 1'b0, 1'b0);
        send_vertex(50, 40, 1'b0, 1'b0);
        send_vertex(50, 40, 1'b1, 1'b0);
        send_vertex(50, 40, 1'b0, 1'b0);
        send_vertex(100, 0, 1'b0, 1'b1);
    endtask

    // more vertices than the store holds: extras are dropped, the last overwrites
    task automatic test_overflow();
        set_tolerance(3);
        for (int i = 0; i < NPTS + 3; i++)
            send_vertex(i * 4, ((i * 37) % 11) - 5, 1'b0, i == NPTS + 2);
    endtask

    task automatic test_backpressure();
        set_tolerance(1);
        @(posedge clk);
        out_hold = 600;
        for (int p = 0; p < 3; p++)
            send_polyline(6, 6);
    endtask

    task automatic test_random();
        int goal;
        int len;
        int r;
        goal = words_sent + 180;
        while (words_sent < goal)
        begin
            case ($urandom_range(0, 4))
                0: set_tolerance(0);
                1: set_tolerance(TOL_MAX);
                default: set_tolerance($urandom_range(0, 1 << $urandom_range(1, 16)));
            endcase
            in_gaps_on    = $urandom_range(0, 3) != 0;
            out_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            for (int p = 0; p < 8; p++)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    len = $urandom_range(1, 2);
                else if (r < 97)
                    len = $urandom_range(3, 12);
                else
                    len = $urandom_range(20, NPTS);
                send_polyline(len, $urandom_range(1, 22));
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_ready <= 1'b0;
            out_hold  <= out_hold - 1;
        end
        else if ($urandom_range(0, 299) == 0)
        begin
            out_ready <= 1'b0;
            out_hold  <= $urandom_range(20, 80);
        end
        else
            out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    always @(posedge clk)
    begin
        pldp_pkg::out_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (kept_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %p", out_data);
            end
            else
            begin
                e = kept_q.pop_front();
                if (out_data.out_x !== e.out_x || out_data.out_y !== e.out_y ||
                    out_data.out_index !== e.out_index || out_data.out_last !== e.out_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", e, out_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pt_count      = 0;
        tol_shadow    = 0;
        mismatches    = 0;
        wdog          = 0;
        out_hold      = 0;
        out_stall_pct = 20;
        in_gaps_on    = 1'b1;
        words_sent    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_short_lines();
        test_extremes();
        test_twin_vertices();
        test_overflow();
        test_backpressure();
        test_random();

        wait_drained();
        if (mismatches == 0 && kept_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
